// ===== sv/gbnfr_pkg.sv =====
// Package: types and codes shared by the Go-Back-N sender and its register block.
package gbnfr_pkg;

  // Event kinds carried in the op field
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Event codes reported with each result
  localparam logic [2:0] EV_SENT     = 3'd0;
  localparam logic [2:0] EV_REFUSED  = 3'd1;
  localparam logic [2:0] EV_ACKED    = 3'd2;
  localparam logic [2:0] EV_BAD_CSUM = 3'd3;
  localparam logic [2:0] EV_DUP      = 3'd4;
  localparam logic [2:0] EV_FAST_RTX = 3'd5;
  localparam logic [2:0] EV_IGNORED  = 3'd6;

  // Configuration register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_DUP_THRESHOLD = 1'b0;
  localparam logic [3:0]  DUP_THRESHOLD_RST = 4'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] payload;
    logic [7:0]  ack_num;
    logic        ack_checksum_ok;
    logic [7:0]  expired_seq;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        window_full;
    logic [2:0]  event_code;
    logic        tx_valid;
    logic [7:0]  tx_seq;
    logic [31:0] tx_payload;
    logic        timer_stop;
    logic [7:0]  timer_stop_seq;
    logic        timer_start;
    logic [7:0]  timer_start_seq;
  } rsp_t;

endpackage

// ===== sv/gbnfr_apb_regs.sv =====
// APB register block holding the duplicate-ack threshold.
module gbnfr_apb_regs
  import gbnfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [3:0]            dup_threshold
);

  logic wr_en;

  // Write completes in the access phase; no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_threshold <= DUP_THRESHOLD_RST;
    end else if (wr_en && (paddr[2] == REG_DUP_THRESHOLD)) begin
      dup_threshold <= pwdata[3:0];
    end
  end

  // Return the register on reads, zero elsewhere
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_DUP_THRESHOLD) begin
      prdata = {28'd0, dup_threshold};
    end
  end

endmodule

// ===== sv/gbn_sender_fast_retransmit_unit.sv =====
// Top level: Go-Back-N sender with fast retransmit, packet store and event engine.
//
// Each event word is accepted when start is high and busy is low. The block
// then holds busy high while it reads the oldest stored packet from the
// synchronous packet store and updates the window; the result word appears
// on rsp with done high for exactly one cycle, the cycle after that. The
// block cannot take a new event while busy is high, and a new event may be
// accepted in the same cycle that the previous result is presented. The
// receiver cannot stall results: each one is valid only while done is high.
// Sequence numbers wrap modulo 2^SEQ_BITS; ports carry the low 8 bits. The
// user must see that the threshold register is written only while no event
// is in flight; the block itself does not enforce this.
module gbn_sender_fast_retransmit_unit
  import gbnfr_pkg::*;
#(
  parameter int WINDOW   = 4,
  parameter int SEQ_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SEQ_MAX = (1 << SEQ_BITS) - 1;
  localparam int EFF_WIN = (WINDOW < SEQ_MAX) ? WINDOW : SEQ_MAX;
  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state;
  logic [3:0]          dup_threshold;
  req_t                req_q;
  logic [SEQ_BITS-1:0] base_seq, base_seq_next;
  logic [SEQ_BITS-1:0] next_seq, next_seq_next;
  logic [3:0]          dup_count, dup_count_next;
  logic [IDX_W-1:0]    head_idx, head_idx_next;
  logic [31:0]         packet_store [WINDOW];
  logic [31:0]         rd_data;
  logic                accept;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  rsp_t                rsp_next;

  logic [SEQ_BITS-1:0] cnt, cnt_next, ack_dist, ack_seq, exp_seq, base_after;
  logic [IDX_W:0]      wr_sum, head_sum;
  logic [3:0]          dup_inc;

  gbnfr_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .dup_threshold (dup_threshold)
  );

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  // Control state and window pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base_seq  <= '0;
      next_seq  <= '0;
      dup_count <= '0;
      head_idx  <= '0;
      done      <= 1'b0;
    end else begin
      done <= busy;
      if (accept) begin
        state <= ST_EXEC;
      end else if (busy) begin
        state     <= ST_IDLE;
        base_seq  <= base_seq_next;
        next_seq  <= next_seq_next;
        dup_count <= dup_count_next;
        head_idx  <= head_idx_next;
      end
    end
  end

  // Capture the event word and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  // Packet store: read the oldest entry on accept, write new payload in execute
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= packet_store[head_idx];
    end
    if (wr_en) begin
      packet_store[wr_idx] <= req_q.payload;
    end
  end

  // Ring index arithmetic, both sums stay below twice the window where their results are used
  always_comb begin
    wr_sum   = {1'b0, head_idx} + (IDX_W + 1)'(cnt);
    head_sum = {1'b0, head_idx} + (IDX_W + 1)'(ack_dist) + (IDX_W + 1)'(1);
    if (wr_sum >= (IDX_W + 1)'(WINDOW)) begin
      wr_sum = wr_sum - (IDX_W + 1)'(WINDOW);
    end
    if (head_sum >= (IDX_W + 1)'(WINDOW)) begin
      head_sum = head_sum - (IDX_W + 1)'(WINDOW);
    end
    wr_idx = IDX_W'(wr_sum);
  end

  // Event handling
  always_comb begin
    cnt        = next_seq - base_seq;
    ack_seq    = SEQ_BITS'(req_q.ack_num);
    exp_seq    = SEQ_BITS'(req_q.expired_seq);
    ack_dist   = ack_seq - base_seq;
    base_after = ack_seq + SEQ_BITS'(1);
    dup_inc    = (dup_count == 4'd15) ? dup_count : dup_count + 4'd1;

    base_seq_next  = base_seq;
    next_seq_next  = next_seq;
    dup_count_next = dup_count;
    head_idx_next  = head_idx;
    wr_en          = 1'b0;
    rsp_next       = '0;
    rsp_next.event_code = EV_IGNORED;

    case (req_q.op)
      OP_SEND: begin
        if (cnt >= SEQ_BITS'(EFF_WIN)) begin
          rsp_next.event_code = EV_REFUSED;
        end else begin
          wr_en               = busy;
          rsp_next.accepted   = 1'b1;
          rsp_next.event_code = EV_SENT;
          rsp_next.tx_valid   = 1'b1;
          rsp_next.tx_seq     = 8'(next_seq);
          rsp_next.tx_payload = req_q.payload;
          if (cnt == '0) begin
            rsp_next.timer_start     = 1'b1;
            rsp_next.timer_start_seq = 8'(base_seq);
          end
          next_seq_next = next_seq + SEQ_BITS'(1);
        end
      end
      OP_ACK: begin
        if (cnt != '0) begin
          if (!req_q.ack_checksum_ok) begin
            rsp_next.event_code = EV_BAD_CSUM;
          end else if (ack_dist < cnt) begin
            rsp_next.event_code     = EV_ACKED;
            rsp_next.timer_stop     = 1'b1;
            rsp_next.timer_stop_seq = 8'(base_seq);
            base_seq_next  = base_after;
            head_idx_next  = IDX_W'(head_sum);
            dup_count_next = '0;
            if (base_after != next_seq) begin
              rsp_next.timer_start     = 1'b1;
              rsp_next.timer_start_seq = 8'(base_after);
            end
          end else if (dup_inc >= dup_threshold) begin
            dup_count_next           = '0;
            rsp_next.event_code      = EV_FAST_RTX;
            rsp_next.timer_stop      = 1'b1;
            rsp_next.timer_stop_seq  = 8'(base_seq);
            rsp_next.timer_start     = 1'b1;
            rsp_next.timer_start_seq = 8'(base_seq);
            rsp_next.tx_valid        = 1'b1;
            rsp_next.tx_seq          = 8'(base_seq);
            rsp_next.tx_payload      = rd_data;
          end else begin
            dup_count_next      = dup_inc;
            rsp_next.event_code = EV_DUP;
          end
        end
      end
      OP_TIMEOUT: begin
        rsp_next.timer_stop     = 1'b1;
        rsp_next.timer_stop_seq = 8'(exp_seq);
        if (cnt != '0) begin
          rsp_next.timer_start     = 1'b1;
          rsp_next.timer_start_seq = 8'(base_seq);
          rsp_next.tx_valid        = 1'b1;
          rsp_next.tx_seq          = 8'(base_seq);
          rsp_next.tx_payload      = rd_data;
        end
      end
      default: begin
        rsp_next.event_code = EV_IGNORED;
      end
    endcase

    cnt_next = next_seq_next - base_seq_next;
    rsp_next.window_full = (cnt_next >= SEQ_BITS'(EFF_WIN));
  end

  // A result word is always preceded by an execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  // Execute lasts a single cycle
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute state held for more than one cycle");

  // Outstanding count never exceeds the effective window
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (next_seq - base_seq) <= SEQ_BITS'(EFF_WIN))
    else $error("outstanding packets exceed the window");

  // An accepted send always transmits and reports sent
  a_send_tx: assert property (@(posedge clk) disable iff (rst)
    done && rsp.accepted |-> rsp.tx_valid && (rsp.event_code == EV_SENT))
    else $error("accepted send without transmission");

  // The store is written only during execute
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> busy)
    else $error("packet store written outside execute");

endmodule
